@@ rtl/bse_pkg.sv @@
// Shared types and constants for the bitset engine with popcount.
// Used by every module in rtl/ except bse_ram; has no dependencies of its own.
`timescale 1ns / 1ps

package bse_pkg;

   localparam int MAX_BITS    = 4096;
   localparam int WORD_BITS   = 64;
   localparam int NUM_WORDS   = MAX_BITS / WORD_BITS;
   localparam int WORD_AW     = $clog2(NUM_WORDS);
   localparam int BIT_AW      = $clog2(WORD_BITS);
   localparam int CNT_W       = 13;
   localparam int POS_W       = 12;
   localparam int OP_W        = 3;
   localparam int WORDS_W     = WORD_AW + 1;
   localparam int POP_W       = $clog2(WORD_BITS + 1);
   localparam int NUM_BYTES   = WORD_BITS / 8;
   localparam int BYTE_CNT_W  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_SET   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
   localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
   localparam logic [OP_W-1:0] OP_MERGE = 3'd4;
   localparam logic [OP_W-1:0] OP_CMP   = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic                 err;
      logic [WORD_AW-1:0]   word_addr;
      logic [BIT_AW-1:0]    bit_idx;
      logic [WORD_BITS-1:0] keep;
      logic [WORD_BITS-1:0] other;
      logic                 len_match;
      logic                 pass_end;
   } item_type;

endpackage

@@ rtl/bse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bse_queue.sv @@
// Short FIFO of classified transactions between front and back end.
// Depends on bse_pkg.
`timescale 1ns / 1ps

module bse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bse_pkg::item_type push_data,
   output logic              full,
   input  logic              pop,
   output bse_pkg::item_type pop_data,
   output logic              empty
);

   localparam int PTR_W = $clog2(bse_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bse_pkg::QUEUE_DEPTH + 1);

   bse_pkg::item_type entry_ff [bse_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(bse_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = (count_ff == CNT_W'(bse_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[head_ff];

   always_comb begin
      head_in  = pop ? next_ptr(head_ff) : head_ff;
      tail_in  = push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

@@ rtl/bse_front.sv @@
// Front end: length register, range checks and decode of each transaction.
// Depends on bse_pkg.
`timescale 1ns / 1ps

module bse_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [bse_pkg::CNT_W-1:0]   csr_length_bits,
   output logic                        vec_clear,
   input  logic [bse_pkg::OP_W-1:0]    req_operation,
   input  logic [bse_pkg::POS_W-1:0]   req_position,
   input  logic [bse_pkg::WORD_BITS-1:0] req_other_word,
   input  logic [bse_pkg::CNT_W-1:0]   req_other_length,
   input  logic                        req_pass_end,
   output bse_pkg::item_type           item
);

   logic [bse_pkg::CNT_W-1:0]   length_ff, length_in;
   logic [bse_pkg::CNT_W-1:0]   eff_len;
   logic [bse_pkg::CNT_W-1:0]   len_round;
   logic [bse_pkg::WORDS_W-1:0] num_words;
   logic [bse_pkg::BIT_AW-1:0]  rem;
   logic                        last_word;

   assign vec_clear = csr_valid;
   assign length_in = csr_valid ? csr_length_bits : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= bse_pkg::CNT_W'(bse_pkg::MAX_BITS);
      end else begin
         length_ff <= length_in;
      end
   end

   always_comb begin
      eff_len   = (length_ff > bse_pkg::CNT_W'(bse_pkg::MAX_BITS)) ?
                  bse_pkg::CNT_W'(bse_pkg::MAX_BITS) : length_ff;
      len_round = eff_len + bse_pkg::CNT_W'(bse_pkg::WORD_BITS - 1);
      num_words = len_round[bse_pkg::CNT_W-1:bse_pkg::BIT_AW];
      rem       = eff_len[bse_pkg::BIT_AW-1:0];
      last_word = ({1'b0, req_position} ==
                   bse_pkg::CNT_W'(num_words) - bse_pkg::CNT_W'(1));

      item.op        = req_operation;
      item.other     = req_other_word;
      item.pass_end  = req_pass_end;
      item.len_match = (req_other_length == eff_len);
      item.bit_idx   = req_position[bse_pkg::BIT_AW-1:0];
      item.keep      = '1;
      if (last_word && rem != '0) begin
         item.keep = (bse_pkg::WORD_BITS'(1) << rem) - bse_pkg::WORD_BITS'(1);
      end

      case (req_operation) inside
         bse_pkg::OP_SET, bse_pkg::OP_CLEAR, bse_pkg::OP_TEST: begin
            item.err       = ({1'b0, req_position} >= eff_len);
            item.word_addr = req_position[bse_pkg::BIT_AW +: bse_pkg::WORD_AW];
         end
         bse_pkg::OP_MERGE, bse_pkg::OP_CMP: begin
            item.err       = ({1'b0, req_position} >= bse_pkg::CNT_W'(num_words));
            item.word_addr = req_position[bse_pkg::WORD_AW-1:0];
         end
         default: begin
            item.err       = 1'b0;
            item.word_addr = '0;
         end
      endcase
   end

endmodule

@@ rtl/bse_back.sv @@
// Back end: word read-modify-write sequencer, counters and result register.
// Depends on bse_pkg and bse_ram.
`timescale 1ns / 1ps

module bse_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      vec_clear,
   input  logic                      q_empty,
   input  bse_pkg::item_type         q_data,
   output logic                      q_pop,
   output logic                      busy,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_bit_value,
   output logic [bse_pkg::CNT_W-1:0] rsp_ones_total,
   output logic [bse_pkg::CNT_W-1:0] rsp_newly_set,
   output logic                      rsp_equal_so_far,
   output logic                      rsp_index_error
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                       state_ff, state_in;
   bse_pkg::item_type                cur_ff;
   logic [bse_pkg::NUM_WORDS-1:0]    wvalid_ff, wvalid_in;
   logic                             rd_vld_ff;
   logic [bse_pkg::WORD_BITS-1:0]    rd_data;
   logic                             was_ff;
   logic                             mism_ff;
   logic [bse_pkg::BYTE_CNT_W-1:0]   byte_cnt_ff [bse_pkg::NUM_BYTES];
   logic [bse_pkg::BYTE_CNT_W-1:0]   byte_cnt_in [bse_pkg::NUM_BYTES];
   logic [bse_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [bse_pkg::CNT_W-1:0]        added_ff, added_in;
   logic                             match_ff, match_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_bit_ff;
   logic [bse_pkg::CNT_W-1:0]        rsp_total_ff;
   logic [bse_pkg::CNT_W-1:0]        rsp_added_ff;
   logic                             rsp_match_ff;
   logic                             rsp_err_ff;

   logic [bse_pkg::WORD_BITS-1:0]    word;
   logic [bse_pkg::WORD_BITS-1:0]    bit_mask;
   logic [bse_pkg::WORD_BITS-1:0]    fresh;
   logic                             was;
   logic                             wr_en;
   logic [bse_pkg::WORD_BITS-1:0]    wr_data;
   logic                             out_free;
   logic                             load_rsp;
   logic [bse_pkg::POP_W-1:0]        pop_sum;
   logic [bse_pkg::CNT_W-1:0]        added_out;
   logic                             match_out;
   logic                             ok;

   bse_ram #(
      .WIDTH (bse_pkg::WORD_BITS),
      .DEPTH (bse_pkg::NUM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff.word_addr),
      .wr_data (wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_data.word_addr),
      .rd_data (rd_data)
   );

   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign busy     = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == ST_DONE) && out_free;
   assign ok       = !cur_ff.err;

   // execute stage: word from memory, modified word, per-byte popcount
   always_comb begin
      word     = rd_vld_ff ? rd_data : '0;
      bit_mask = bse_pkg::WORD_BITS'(1) << cur_ff.bit_idx;
      was      = word[cur_ff.bit_idx];
      fresh    = cur_ff.other & cur_ff.keep & ~word;
      wr_en    = 1'b0;
      wr_data  = word;
      if (state_ff == ST_EXEC && ok) begin
         case (cur_ff.op)
            bse_pkg::OP_SET: begin
               wr_en   = !was;
               wr_data = word | bit_mask;
            end
            bse_pkg::OP_CLEAR: begin
               wr_en   = was;
               wr_data = word & ~bit_mask;
            end
            bse_pkg::OP_MERGE: begin
               wr_en   = 1'b1;
               wr_data = word | fresh;
            end
            default: begin
               wr_en   = 1'b0;
               wr_data = word;
            end
         endcase
      end
      for (int b = 0; b < bse_pkg::NUM_BYTES; b++) begin
         byte_cnt_in[b] = '0;
         for (int i = 0; i < 8; i++) begin
            byte_cnt_in[b] = byte_cnt_in[b] + bse_pkg::BYTE_CNT_W'(fresh[b*8 + i]);
         end
      end
   end

   // completion stage: counters and result
   always_comb begin
      pop_sum = '0;
      for (int b = 0; b < bse_pkg::NUM_BYTES; b++) begin
         pop_sum = pop_sum + bse_pkg::POP_W'(byte_cnt_ff[b]);
      end
      count_in  = count_ff;
      added_out = added_ff;
      match_out = match_ff;
      if (ok) begin
         case (cur_ff.op)
            bse_pkg::OP_SET: begin
               if (!was_ff) count_in = count_ff + bse_pkg::CNT_W'(1);
            end
            bse_pkg::OP_CLEAR: begin
               if (was_ff) count_in = count_ff - bse_pkg::CNT_W'(1);
            end
            bse_pkg::OP_MERGE: begin
               count_in  = count_ff + bse_pkg::CNT_W'(pop_sum);
               added_out = added_ff + bse_pkg::CNT_W'(pop_sum);
            end
            bse_pkg::OP_CMP: begin
               match_out = match_ff && !mism_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      added_in = added_out;
      match_in = match_out;
      if (cur_ff.pass_end && cur_ff.op == bse_pkg::OP_MERGE) added_in = '0;
      if (cur_ff.pass_end && cur_ff.op == bse_pkg::OP_CMP) match_in = 1'b1;
      if (!load_rsp) begin
         count_in = count_ff;
         added_in = added_ff;
         match_in = match_ff;
      end
      if (vec_clear) begin
         count_in = '0;
         added_in = '0;
         match_in = 1'b1;
      end

      wvalid_in = wvalid_ff;
      if (wr_en) wvalid_in[cur_ff.word_addr] = 1'b1;
      if (vec_clear) wvalid_in = '0;

      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wvalid_ff    <= '0;
         count_ff     <= '0;
         added_ff     <= '0;
         match_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wvalid_ff    <= wvalid_in;
         count_ff     <= count_in;
         added_ff     <= added_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff    <= q_data;
         rd_vld_ff <= wvalid_ff[q_data.word_addr];
      end
      if (state_ff == ST_EXEC) begin
         was_ff      <= was;
         mism_ff     <= (word != cur_ff.other) || !cur_ff.len_match;
         byte_cnt_ff <= byte_cnt_in;
      end
      if (load_rsp) begin
         rsp_bit_ff   <= ok && (cur_ff.op == bse_pkg::OP_TEST) && was_ff;
         rsp_total_ff <= count_in;
         rsp_added_ff <= added_out;
         rsp_match_ff <= match_out;
         rsp_err_ff   <= cur_ff.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bit_value    = rsp_bit_ff;
   assign rsp_ones_total   = rsp_total_ff;
   assign rsp_newly_set    = rsp_added_ff;
   assign rsp_equal_so_far = rsp_match_ff;
   assign rsp_index_error  = rsp_err_ff;

endmodule

@@ rtl/bitset_engine_with_popcount_core.sv @@
// Top level of the bitset engine with popcount: front end, queue, back end.
// Depends on bse_pkg, bse_front, bse_queue, bse_back (and bse_ram below it).
`timescale 1ns / 1ps

// Usage:
//  - req_* carries one transaction (operation, position, other_word,
//    other_length, pass_end); taken when req_valid is high and req_stall low.
//    req_stall rises when the two-entry queue behind the front end is full.
//  - rsp_* returns exactly one result per transaction, in order; it is taken
//    when rsp_valid is high and rsp_stall low. A stalled result holds steady
//    while the queue keeps taking requests until it is full.
//  - csr_* writes length_bits; csr_ready is always high. A write empties the
//    vector, the count and both pass accumulators in the same cycle. Write it
//    only while no transaction is in flight.
//  - Sequence: a transaction passes the queue, then the back end reads its
//    word (IDLE), executes and writes it (EXEC) and updates the counters into
//    the output register (DONE). This read/modify/write sequence on the word
//    memory finishes before the next transaction leaves the queue; DONE waits while the output is stalled.
//  - Reset (synchronous, active high) clears the vector through per-word valid
//    bits; length_bits returns to 4096. No clearing pass.
module bitset_engine_with_popcount_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bse_pkg::OP_W-1:0]      req_operation,
   input  logic [bse_pkg::POS_W-1:0]     req_position,
   input  logic [bse_pkg::WORD_BITS-1:0] req_other_word,
   input  logic [bse_pkg::CNT_W-1:0]     req_other_length,
   input  logic                          req_pass_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_bit_value,
   output logic [bse_pkg::CNT_W-1:0]     rsp_ones_total,
   output logic [bse_pkg::CNT_W-1:0]     rsp_newly_set,
   output logic                          rsp_equal_so_far,
   output logic                          rsp_index_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bse_pkg::CNT_W-1:0]     csr_length_bits
);

   bse_pkg::item_type front_item;
   bse_pkg::item_type q_data;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic              q_push;
   logic              vec_clear;
   logic              back_busy;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready && !back_busy;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   bse_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid && csr_ready),
      .csr_length_bits  (csr_length_bits),
      .vec_clear        (vec_clear),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_other_word   (req_other_word),
      .req_other_length (req_other_length),
      .req_pass_end     (req_pass_end),
      .item             (front_item)
   );

   bse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   bse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .vec_clear        (vec_clear || csr_write),
      .q_empty          (q_empty),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .busy             (back_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_ones_total   (rsp_ones_total),
      .rsp_newly_set    (rsp_newly_set),
      .rsp_equal_so_far (rsp_equal_so_far),
      .rsp_index_error  (rsp_index_error)
   );

endmodule
